// ===== rtl/core/hrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Shared types, result codes, register indexes and character helpers.
// ----------------------------------------------------------------------------
package hrp_pkg;

    // result kinds
    localparam logic [3:0] KIND_METHOD   = 4'd0;
    localparam logic [3:0] KIND_RESOURCE = 4'd1;
    localparam logic [3:0] KIND_VERSION  = 4'd2;
    localparam logic [3:0] KIND_KEY      = 4'd3;
    localparam logic [3:0] KIND_VALUE    = 4'd4;
    localparam logic [3:0] KIND_BODY     = 4'd5;
    localparam logic [3:0] KIND_FIELD_END = 4'd6;
    localparam logic [3:0] KIND_ACCEPT   = 4'd7;
    localparam logic [3:0] KIND_REJECT   = 4'd8;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam logic [CFG_INDEX_W-1:0] CFG_METHOD_LIMIT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESOURCE_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERSION_LIMIT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_LIMIT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_HEADERS    = 3'd4;

    localparam logic [7:0]  RST_METHOD_LIMIT   = 8'd7;
    localparam logic [9:0]  RST_RESOURCE_LIMIT = 10'd255;
    localparam logic [7:0]  RST_VERSION_LIMIT  = 8'd15;
    localparam logic [11:0] RST_LINE_LIMIT     = 12'd511;
    localparam logic [7:0]  RST_MAX_HEADERS    = 8'd32;

    // characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int RES_SLOTS = 3;

    typedef struct packed {
        logic [7:0]  method_limit;
        logic [9:0]  resource_limit;
        logic [7:0]  version_limit;
        logic [11:0] line_limit;
        logic [7:0]  max_headers;
    } cfg_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] value;
        logic [7:0] header_index;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]                   count;
        result_t [RES_SLOTS-1:0]      data;
    } push_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/hrp_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser channels
// Valid/ready interfaces for raw request bytes and parse results.
// ----------------------------------------------------------------------------
interface hrp_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_request;

    modport source (output valid, output data_byte, output end_of_request, input ready);
    modport sink   (input valid, input data_byte, input end_of_request, output ready);
endinterface

interface hrp_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] value;
    logic [7:0] header_index;
    logic       last;

    modport source (output valid, output kind, output value, output header_index,
                    output last, input ready);
    modport sink   (input valid, input kind, input value, input header_index,
                    input last, output ready);
endinterface

// ===== rtl/core/hrp_result_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser result queue
// Four-entry queue taking up to three results a cycle, one transfer out.
// ----------------------------------------------------------------------------
module hrp_result_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  hrp_pkg::push_t push,
    output logic           room,
    hrp_res_if.source      result
);
    import hrp_pkg::*;

    localparam int QDEPTH = 4;

    result_t    mem_reg [QDEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign pop  = result.valid && result.ready;
    assign room = (count_reg <= 3'd1) || (count_reg == 3'd2 && pop);

    assign result.valid        = (count_reg != 3'd0);
    assign result.kind         = mem_reg[rd_ptr_reg].kind;
    assign result.value        = mem_reg[rd_ptr_reg].value;
    assign result.header_index = mem_reg[rd_ptr_reg].header_index;
    assign result.last         = mem_reg[rd_ptr_reg].last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RES_SLOTS; k++)
        begin
            if (2'(k) < push.count)
            begin
                mem_reg[wr_ptr_reg + 2'(k)] <= push.data[k];
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(QDEPTH))
        else $error("result queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> ({1'b0, count_reg} - {3'b0, pop} + {2'b0, push.count}) <= 4'(QDEPTH))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 && !pop |=> count_reg != 3'd0)
        else $error("pushed results lost");

endmodule

// ===== rtl/core/hrp_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser engine
// Input byte register and the per-byte parse step producing up to three results.
// ----------------------------------------------------------------------------
module hrp_engine (
    input  logic            clk,
    input  logic            rst_n,
    hrp_req_if.sink         request,
    input  hrp_pkg::cfg_t   cfg,
    input  logic            room,
    output hrp_pkg::push_t  push
);
    import hrp_pkg::*;

    localparam logic [3:0] PH_LEAD   = 4'd0;
    localparam logic [3:0] PH_METHOD = 4'd1;
    localparam logic [3:0] PH_GAP1   = 4'd2;
    localparam logic [3:0] PH_RES    = 4'd3;
    localparam logic [3:0] PH_GAP2   = 4'd4;
    localparam logic [3:0] PH_VER    = 4'd5;
    localparam logic [3:0] PH_TAIL   = 4'd6;
    localparam logic [3:0] PH_KEY    = 4'd7;
    localparam logic [3:0] PH_VPRE   = 4'd8;
    localparam logic [3:0] PH_VAL    = 4'd9;
    localparam logic [3:0] PH_SKIP   = 4'd10;
    localparam logic [3:0] PH_BODY   = 4'd11;
    localparam logic [3:0] PH_DRAIN  = 4'd12;

    logic        stage_valid_reg;
    logic [7:0]  byte_reg;
    logic        eor_reg;
    logic        fire;

    logic [3:0]  phase_reg,     phase_next;
    logic [11:0] field_len_reg, field_len_next;
    logic [11:0] line_len_reg,  line_len_next;
    logic [7:0]  headers_reg,   headers_next;
    logic        cr_pend_reg,   cr_pend_next;
    logic [1:0]  pct_reg,       pct_next;
    logic [7:0]  held_reg,      held_next;

    logic [3:0]  last_kind;

    function automatic result_t mk(input logic [3:0] k, input logic [7:0] v,
                                   input logic [7:0] idx);
        result_t r;
        r.kind         = k;
        r.value        = v;
        r.header_index = idx;
        r.last         = 1'b0;
        return r;
    endfunction

    assign fire          = stage_valid_reg && room;
    assign request.ready = !stage_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            stage_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            byte_reg <= request.data_byte;
            eor_reg  <= request.end_of_request;
        end
    end

    always_comb
    begin
        logic [7:0] tc;
        logic       act;
        logic       deferred;
        logic       cr_only;
        logic       ws;
        logic       fail_now;
        logic       blank_done;
        logic [4:0] hi;
        logic [4:0] lo;
        logic [7:0] dec;
        logic [1:0] n;

        phase_next     = phase_reg;
        field_len_next = field_len_reg;
        line_len_next  = line_len_reg;
        headers_next   = headers_reg;
        cr_pend_next   = cr_pend_reg;
        pct_next       = pct_reg;
        held_next      = held_reg;
        push           = '0;
        n              = 2'd0;
        fail_now       = 1'b0;
        tc             = 8'd0;
        act            = 1'b0;
        deferred       = 1'b0;
        cr_only        = 1'b0;
        ws             = 1'b0;
        hi             = 5'd0;
        lo             = 5'd0;
        dec            = 8'd0;
        blank_done     = cr_pend_reg && byte_reg == CH_LF && line_len_reg == 12'd0 &&
                         (phase_reg == PH_KEY || phase_reg == PH_SKIP);

        if (fire)
        begin
            if (phase_reg == PH_DRAIN)
            begin
                if (eor_reg)
                begin
                    phase_next = PH_LEAD;
                end
            end
            else if (eor_reg && phase_reg != PH_BODY && !blank_done)
            begin
                push.data[n] = mk(KIND_REJECT, 8'd0, 8'd0);
                n = n + 2'd1;
                phase_next     = PH_LEAD;
                field_len_next = 12'd0;
                line_len_next  = 12'd0;
                headers_next   = 8'd0;
                cr_pend_next   = 1'b0;
                pct_next       = 2'd0;
                held_next      = 8'd0;
            end
            else if (phase_reg == PH_BODY)
            begin
                push.data[n] = mk(KIND_BODY, byte_reg, 8'd0);
                n = n + 2'd1;
                if (eor_reg)
                begin
                    push.data[n] = mk(KIND_ACCEPT, 8'd0, 8'd0);
                    n = n + 2'd1;
                    phase_next     = PH_LEAD;
                    field_len_next = 12'd0;
                    line_len_next  = 12'd0;
                    headers_next   = 8'd0;
                    cr_pend_next   = 1'b0;
                    pct_next       = 2'd0;
                    held_next      = 8'd0;
                end
            end
            else if (cr_pend_reg && byte_reg == CH_LF)
            begin
                // line end
                cr_pend_next = 1'b0;
                if (phase_reg <= PH_TAIL)
                begin
                    if (phase_reg != PH_TAIL)
                    begin
                        fail_now = 1'b1;
                    end
                    else
                    begin
                        phase_next     = PH_KEY;
                        line_len_next  = 12'd0;
                        field_len_next = 12'd0;
                    end
                end
                else if (phase_reg == PH_KEY || phase_reg == PH_SKIP)
                begin
                    if (line_len_reg == 12'd0)
                    begin
                        phase_next = PH_BODY;
                    end
                    else if (phase_reg == PH_KEY)
                    begin
                        fail_now = 1'b1;
                    end
                    else
                    begin
                        line_len_next  = 12'd0;
                        field_len_next = 12'd0;
                    end
                end
                else if (phase_reg == PH_VPRE)
                begin
                    fail_now = 1'b1;
                end
                else
                begin
                    push.data[n] = mk(KIND_FIELD_END, 8'd0, headers_reg);
                    n = n + 2'd1;
                    headers_next   = headers_reg + 8'd1;
                    phase_next     = (headers_next >= cfg.max_headers) ? PH_SKIP : PH_KEY;
                    line_len_next  = 12'd0;
                    field_len_next = 12'd0;
                end

                if (eor_reg && phase_next == PH_BODY)
                begin
                    push.data[n] = mk(KIND_ACCEPT, 8'd0, 8'd0);
                    n = n + 2'd1;
                    phase_next     = PH_LEAD;
                    field_len_next = 12'd0;
                    line_len_next  = 12'd0;
                    headers_next   = 8'd0;
                    cr_pend_next   = 1'b0;
                    pct_next       = 2'd0;
                    held_next      = 8'd0;
                end
            end
            else
            begin
                cr_pend_next = 1'b0;
                // pass 0: held CR, pass 1: this byte
                for (int p = 0; p < 2; p++)
                begin
                    if (p == 0)
                    begin
                        act      = cr_pend_reg;
                        tc       = CH_CR;
                        deferred = 1'b1;
                        cr_only  = 1'b0;
                    end
                    else
                    begin
                        act      = 1'b1;
                        tc       = byte_reg;
                        deferred = 1'b0;
                        cr_only  = (byte_reg == CH_CR);
                    end
                    ws = is_space(tc);

                    if (act && phase_next != PH_DRAIN && !fail_now)
                    begin
                        if (phase_next <= PH_TAIL)
                        begin
                            if (!cr_only && line_len_next >= cfg.line_limit)
                            begin
                                fail_now = 1'b1;
                            end
                            else
                            begin
                                if (!cr_only)
                                begin
                                    line_len_next = line_len_next + 12'd1;
                                end
                                if (!deferred)
                                begin
                                    // token split
                                    if (phase_next inside {PH_LEAD, PH_GAP1, PH_GAP2} && !ws)
                                    begin
                                        phase_next     = phase_next + 4'd1;
                                        field_len_next = 12'd0;
                                        pct_next       = 2'd0;
                                    end
                                    case (phase_next)
                                        PH_METHOD:
                                        begin
                                            if (ws)
                                            begin
                                                push.data[n] = mk(KIND_FIELD_END, 8'd0, 8'd0);
                                                n = n + 2'd1;
                                                phase_next = PH_GAP1;
                                            end
                                            else if (field_len_next >= {4'd0, cfg.method_limit})
                                            begin
                                                fail_now = 1'b1;
                                            end
                                            else
                                            begin
                                                field_len_next = field_len_next + 12'd1;
                                                push.data[n] = mk(KIND_METHOD, tc, 8'd0);
                                                n = n + 2'd1;
                                            end
                                        end
                                        PH_RES:
                                        begin
                                            if (ws)
                                            begin
                                                if (pct_next != 2'd0)
                                                begin
                                                    push.data[n] = mk(KIND_RESOURCE, CH_PCT, 8'd0);
                                                    n = n + 2'd1;
                                                end
                                                if (pct_next == 2'd2)
                                                begin
                                                    push.data[n] = mk(KIND_RESOURCE, held_next, 8'd0);
                                                    n = n + 2'd1;
                                                end
                                                pct_next = 2'd0;
                                                push.data[n] = mk(KIND_FIELD_END, 8'd0, 8'd0);
                                                n = n + 2'd1;
                                                phase_next = PH_GAP2;
                                            end
                                            else if (field_len_next >= {2'd0, cfg.resource_limit})
                                            begin
                                                fail_now = 1'b1;
                                            end
                                            else
                                            begin
                                                field_len_next = field_len_next + 12'd1;
                                                if (pct_next == 2'd0)
                                                begin
                                                    if (tc == CH_PCT)
                                                    begin
                                                        pct_next = 2'd1;
                                                    end
                                                    else
                                                    begin
                                                        push.data[n] = mk(KIND_RESOURCE,
                                                            (tc == CH_PLUS) ? CH_SP : tc, 8'd0);
                                                        n = n + 2'd1;
                                                    end
                                                end
                                                else if (pct_next == 2'd1)
                                                begin
                                                    held_next = tc;
                                                    pct_next  = 2'd2;
                                                end
                                                else
                                                begin
                                                    hi = hex_val(held_next);
                                                    lo = hex_val(tc);
                                                    if (!hi[4])
                                                    begin
                                                        dec = 8'd0;
                                                    end
                                                    else if (lo[4])
                                                    begin
                                                        dec = {hi[3:0], lo[3:0]};
                                                    end
                                                    else
                                                    begin
                                                        dec = {4'd0, hi[3:0]};
                                                    end
                                                    push.data[n] = mk(KIND_RESOURCE, dec, 8'd0);
                                                    n = n + 2'd1;
                                                    pct_next = 2'd0;
                                                end
                                            end
                                        end
                                        PH_VER:
                                        begin
                                            if (ws)
                                            begin
                                                push.data[n] = mk(KIND_FIELD_END, 8'd0, 8'd0);
                                                n = n + 2'd1;
                                                phase_next = PH_TAIL;
                                            end
                                            else if (field_len_next >= {4'd0, cfg.version_limit})
                                            begin
                                                fail_now = 1'b1;
                                            end
                                            else
                                            begin
                                                field_len_next = field_len_next + 12'd1;
                                                push.data[n] = mk(KIND_VERSION, tc, 8'd0);
                                                n = n + 2'd1;
                                            end
                                        end
                                        default:
                                        begin
                                        end
                                    endcase
                                end
                            end
                        end
                        else if (cr_only)
                        begin
                        end
                        else if (phase_next == PH_SKIP)
                        begin
                            line_len_next = 12'd1;
                        end
                        else if (line_len_next >= cfg.line_limit)
                        begin
                            fail_now = 1'b1;
                        end
                        else
                        begin
                            line_len_next = line_len_next + 12'd1;
                            if (phase_next == PH_KEY)
                            begin
                                if (tc == CH_COLON)
                                begin
                                    if (field_len_next == 12'd0)
                                    begin
                                        fail_now = 1'b1;
                                    end
                                    else
                                    begin
                                        push.data[n] = mk(KIND_FIELD_END, 8'd0, headers_next);
                                        n = n + 2'd1;
                                        phase_next = PH_VPRE;
                                    end
                                end
                                else
                                begin
                                    push.data[n] = mk(KIND_KEY, tc, headers_next);
                                    n = n + 2'd1;
                                    if (field_len_next != 12'hFFF)
                                    begin
                                        field_len_next = field_len_next + 12'd1;
                                    end
                                end
                            end
                            else if (phase_next == PH_VPRE)
                            begin
                                if (tc != CH_SP)
                                begin
                                    phase_next = PH_VAL;
                                    push.data[n] = mk(KIND_VALUE, tc, headers_next);
                                    n = n + 2'd1;
                                end
                            end
                            else if (phase_next == PH_VAL)
                            begin
                                push.data[n] = mk(KIND_VALUE, tc, headers_next);
                                n = n + 2'd1;
                            end
                        end
                    end
                end
                if (byte_reg == CH_CR && phase_next != PH_DRAIN && !fail_now)
                begin
                    cr_pend_next = 1'b1;
                end
            end

            if (fail_now)
            begin
                push.data[n] = mk(KIND_REJECT, 8'd0, 8'd0);
                n = n + 2'd1;
                phase_next     = PH_DRAIN;
                field_len_next = 12'd0;
                line_len_next  = 12'd0;
                headers_next   = 8'd0;
                cr_pend_next   = 1'b0;
                pct_next       = 2'd0;
                held_next      = 8'd0;
            end
        end

        push.count = n;
        if (n != 2'd0)
        begin
            push.data[n - 2'd1].last = 1'b1;
        end
    end

    assign last_kind = (push.count != 2'd0) ? push.data[push.count - 2'd1].kind : KIND_METHOD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            field_len_reg <= 12'd0;
            line_len_reg  <= 12'd0;
            headers_reg   <= 8'd0;
            cr_pend_reg   <= 1'b0;
            pct_reg       <= 2'd0;
            held_reg      <= 8'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            field_len_reg <= field_len_next;
            line_len_reg  <= line_len_next;
            headers_reg   <= headers_next;
            cr_pend_reg   <= cr_pend_next;
            pct_reg       <= pct_next;
            held_reg      <= held_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && eor_reg && phase_reg != PH_DRAIN |->
            push.count != 2'd0 && (last_kind == KIND_ACCEPT || last_kind == KIND_REJECT))
        else $error("request end without verdict");

    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !room |=> stage_valid_reg && $stable(byte_reg) && $stable(eor_reg))
        else $error("stalled byte not held");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_kind == KIND_REJECT && push.count != 2'd0 |=>
            phase_reg == PH_DRAIN || phase_reg == PH_LEAD)
        else $error("reject without restart");

    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> push.count == 2'd0)
        else $error("results without a byte");

endmodule

// ===== rtl/core/http_request_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser
// Splits a raw request byte stream into tagged fields, headers and body.
//
//   Channel   Dir  Payload                              Handshake
//   request   in   data_byte, end_of_request            valid/ready
//   result    out  kind, value, header_index, last      valid/ready
//   cfg       in   cfg_index, cfg_data                  cfg_write, no stall
//
// One byte a cycle while each byte gives at most one result. A byte with two or
// three results needs extra result transfers, since one result transfers
// per cycle; the four-entry queue absorbs one extra result, beyond that
// request.ready drops until the queue has room again.
// A transferred byte is registered in the engine, then its results are registered in the queue.
// rst_n clears the parse state, the queue and the limits to their defaults.
// A stalled result side fills the queue, then holds request.ready low.
// ----------------------------------------------------------------------------
module http_request_header_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    hrp_req_if.sink                          request,
    hrp_res_if.source                        result,
    input  logic                             cfg_write,
    input  logic [hrp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hrp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hrp_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    push_t push;
    logic  room;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_METHOD_LIMIT:   cfg_next.method_limit   = cfg_data[7:0];
                CFG_RESOURCE_LIMIT: cfg_next.resource_limit = cfg_data[9:0];
                CFG_VERSION_LIMIT:  cfg_next.version_limit  = cfg_data[7:0];
                CFG_LINE_LIMIT:     cfg_next.line_limit     = cfg_data[11:0];
                CFG_MAX_HEADERS:    cfg_next.max_headers    = cfg_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.method_limit   <= RST_METHOD_LIMIT;
            cfg_reg.resource_limit <= RST_RESOURCE_LIMIT;
            cfg_reg.version_limit  <= RST_VERSION_LIMIT;
            cfg_reg.line_limit     <= RST_LINE_LIMIT;
            cfg_reg.max_headers    <= RST_MAX_HEADERS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hrp_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cfg     (cfg_reg),
        .room    (room),
        .push    (push)
    );

    hrp_result_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser testbench
// Streams short raw requests, mostly well formed with random content, some
// broken or noise, through the request channel under several limit settings.
// A cycle-free parser model predicts every tagged field, header and verdict,
// and each result transfer is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb;
    import hrp_pkg::*;

    typedef enum logic [3:0] {
        ST_LINE_START, ST_METHOD, ST_GAP_A, ST_URI, ST_GAP_B, ST_PROTO, ST_LINE_REST,
        ST_HDR_KEY, ST_HDR_PAD, ST_HDR_VAL, ST_HDR_SKIP, ST_BODY, ST_DISCARD
    } parse_state_t;

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    typedef struct {
        logic [7:0] data;
        logic       eor;
        logic       drain_first;
    } req_byte_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    hrp_req_if req_ch ();
    hrp_res_if res_ch ();

    http_request_header_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_ch),
        .result    (res_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    req_byte_t    request_q [$];
    result_t      parsed_q [$];
    logic [7:0]   draft [$];
    int           sent_bytes = 0;
    int           errors = 0;
    logic         req_taken = 1'b0;
    logic         no_idle = 1'b0;

    logic [7:0]   lim_method;
    logic [9:0]   lim_uri;
    logic [7:0]   lim_proto;
    logic [11:0]  lim_line;
    logic [7:0]   lim_hdrs;

    parse_state_t st;
    logic [11:0]  tok_len;
    logic [11:0]  line_len;
    logic [7:0]   hdr_num;
    logic         cr_seen;
    logic [1:0]   esc_state;
    logic [7:0]   esc_digit;
    result_t      step_out [RES_SLOTS];
    int           step_n;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b1, 4'(c - 8'h30)};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return {1'b1, 4'(c - 8'h57)};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return {1'b1, 4'(c - 8'h37)};
        end
        return 5'd0;
    endfunction

    function automatic void post(input logic [3:0] k, input logic [7:0] v,
                                 input logic [7:0] idx);
        if (step_n < RES_SLOTS)
        begin
            step_out[step_n] = '{kind: k, value: v, header_index: idx, last: 1'b0};
            step_n++;
        end
    endfunction

    function automatic void reset_parser();
        st        = ST_LINE_START;
        tok_len   = '0;
        line_len  = '0;
        hdr_num   = '0;
        cr_seen   = 1'b0;
        esc_state = ESC_NONE;
        esc_digit = '0;
    endfunction

    function automatic void abort_request();
        post(KIND_REJECT, 8'd0, 8'd0);
        reset_parser();
        st = ST_DISCARD;
    endfunction

    function automatic logic count_line();
        if (line_len >= lim_line)
        begin
            abort_request();
            return 1'b0;
        end
        line_len++;
        return 1'b1;
    endfunction

    function automatic void token_char(input logic [3:0] k, input logic [11:0] limit,
                                       input logic [7:0] c);
        logic [4:0] hi;
        logic [4:0] lo;
        logic [7:0] v;
        if (tok_len >= limit)
        begin
            abort_request();
            return;
        end
        tok_len++;
        if (k != KIND_RESOURCE)
        begin
            post(k, c, 8'd0);
            return;
        end
        if (esc_state == ESC_NONE)
        begin
            if (c == CH_PCT)
                esc_state = ESC_PCT;
            else
                post(KIND_RESOURCE, (c == CH_PLUS) ? CH_SP : c, 8'd0);
        end
        else if (esc_state == ESC_PCT)
        begin
            esc_digit = c;
            esc_state = ESC_DIGIT;
        end
        else
        begin
            hi = hex_nibble(esc_digit);
            lo = hex_nibble(c);
            v  = 8'd0;
            if (hi[4])
                v = lo[4] ? {hi[3:0], lo[3:0]} : {4'd0, hi[3:0]};
            post(KIND_RESOURCE, v, 8'd0);
            esc_state = ESC_NONE;
        end
    endfunction

    function automatic void close_uri();
        if (esc_state != ESC_NONE)
            post(KIND_RESOURCE, CH_PCT, 8'd0);
        if (esc_state == ESC_DIGIT)
            post(KIND_RESOURCE, esc_digit, 8'd0);
        esc_state = ESC_NONE;
        post(KIND_FIELD_END, 8'd0, 8'd0);
    endfunction

    function automatic void line_char(input logic [7:0] c);
        logic ws;
        ws = is_white(c);
        if (st == ST_LINE_START || st == ST_GAP_A || st == ST_GAP_B)
        begin
            if (ws)
                return;
            st        = parse_state_t'(st + 4'd1);
            tok_len   = '0;
            esc_state = ESC_NONE;
        end
        case (st)
            ST_METHOD:
            begin
                if (ws)
                begin
                    post(KIND_FIELD_END, 8'd0, 8'd0);
                    st = ST_GAP_A;
                end
                else
                    token_char(KIND_METHOD, 12'(lim_method), c);
            end
            ST_URI:
            begin
                if (ws)
                begin
                    close_uri();
                    st = ST_GAP_B;
                end
                else
                    token_char(KIND_RESOURCE, 12'(lim_uri), c);
            end
            ST_PROTO:
            begin
                if (ws)
                begin
                    post(KIND_FIELD_END, 8'd0, 8'd0);
                    st = ST_LINE_REST;
                end
                else
                    token_char(KIND_VERSION, 12'(lim_proto), c);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void header_char(input logic [7:0] c);
        if (st == ST_HDR_KEY)
        begin
            if (c == CH_COLON)
            begin
                if (tok_len == 0)
                begin
                    abort_request();
                    return;
                end
                post(KIND_FIELD_END, 8'd0, hdr_num);
                st = ST_HDR_PAD;
            end
            else
            begin
                post(KIND_KEY, c, hdr_num);
                if (tok_len < 12'hFFF)
                    tok_len++;
            end
        end
        else if (st == ST_HDR_PAD)
        begin
            if (c != CH_SP)
            begin
                st = ST_HDR_VAL;
                post(KIND_VALUE, c, hdr_num);
            end
        end
        else if (st == ST_HDR_VAL)
            post(KIND_VALUE, c, hdr_num);
    endfunction

    function automatic void take_char(input logic [7:0] c, input logic cr_replay);
        if (st == ST_DISCARD)
            return;
        if (st <= ST_LINE_REST)
        begin
            if (count_line() && !cr_replay)
                line_char(c);
        end
        else if (st == ST_HDR_SKIP)
            line_len = 12'd1;
        else if (count_line())
            header_char(c);
    endfunction

    function automatic void line_end();
        if (st <= ST_LINE_REST)
        begin
            if (st != ST_LINE_REST)
            begin
                abort_request();
                return;
            end
            st = ST_HDR_KEY;
        end
        else if (st == ST_HDR_KEY || st == ST_HDR_SKIP)
        begin
            if (line_len == 0)
            begin
                st = ST_BODY;
                return;
            end
            if (st == ST_HDR_KEY)
            begin
                abort_request();
                return;
            end
        end
        else if (st == ST_HDR_PAD)
        begin
            abort_request();
            return;
        end
        else if (st == ST_HDR_VAL)
        begin
            post(KIND_FIELD_END, 8'd0, hdr_num);
            hdr_num = hdr_num + 8'd1;
            st = (hdr_num >= lim_hdrs) ? ST_HDR_SKIP : ST_HDR_KEY;
        end
        line_len = '0;
        tok_len  = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] c, input logic fin);
        logic    blank;
        result_t r;
        step_n = 0;
        if (st == ST_DISCARD)
        begin
            if (fin)
                reset_parser();
            return;
        end
        blank = cr_seen && c == CH_LF && line_len == 0 &&
                (st == ST_HDR_KEY || st == ST_HDR_SKIP);
        if (fin && st != ST_BODY && !blank)
        begin
            post(KIND_REJECT, 8'd0, 8'd0);
            reset_parser();
        end
        else if (st == ST_BODY)
        begin
            post(KIND_BODY, c, 8'd0);
            if (fin)
            begin
                post(KIND_ACCEPT, 8'd0, 8'd0);
                reset_parser();
            end
        end
        else if (cr_seen && c == CH_LF)
        begin
            cr_seen = 1'b0;
            line_end();
            if (fin && st == ST_BODY)
            begin
                post(KIND_ACCEPT, 8'd0, 8'd0);
                reset_parser();
            end
        end
        else
        begin
            if (cr_seen)
            begin
                cr_seen = 1'b0;
                take_char(CH_CR, 1'b1);
            end
            if (st != ST_DISCARD)
            begin
                if (c == CH_CR)
                begin
                    if (st <= ST_LINE_REST)
                        line_char(c);
                    if (st != ST_DISCARD)
                        cr_seen = 1'b1;
                end
                else
                    take_char(c, 1'b0);
            end
        end
        for (int i = 0; i < step_n; i++)
        begin
            r = step_out[i];
            r.last = (i == step_n - 1);
            parsed_q.push_back(r);
        end
    endfunction

    function automatic void flag_mismatch(input string what, input result_t want,
                                          input result_t got);
        errors++;
        if (errors <= 10)
            $display("%s: exp k%0d v%02h i%0d l%0b, got k%0d v%02h i%0d l%0b", what,
                     want.kind, want.value, want.header_index, want.last,
                     got.kind, got.value, got.header_index, got.last);
    endfunction

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (rst_n)
        begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
                parse_byte(req_ch.data_byte, req_ch.end_of_request);
            if (res_ch.valid && res_ch.ready)
            begin
                got = '{kind: res_ch.kind, value: res_ch.value,
                        header_index: res_ch.header_index, last: res_ch.last};
                if (parsed_q.size() == 0)
                    flag_mismatch("unexpected result", '0, got);
                else
                begin
                    want = parsed_q.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value ||
                        got.header_index !== want.header_index || got.last !== want.last)
                        flag_mismatch("mismatch", want, got);
                end
            end
        end
    end

    always @(negedge clk)
    begin : driver
        req_byte_t item;
        if (rst_n)
        begin
            if (!req_ch.valid || req_taken)
            begin
                if (request_q.size() != 0 &&
                    (!request_q[0].drain_first || parsed_q.size() == 0) &&
                    (no_idle || $urandom_range(99) >= 29))
                begin
                    item = request_q.pop_front();
                    req_ch.valid          <= 1'b1;
                    req_ch.data_byte      <= item.data;
                    req_ch.end_of_request <= item.eor;
                end
                else
                    req_ch.valid <= 1'b0;
            end
            res_ch.ready <= no_idle || ($urandom_range(99) >= 29);
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        case (idx)
            CFG_METHOD_LIMIT:   lim_method = 8'(val);
            CFG_RESOURCE_LIMIT: lim_uri    = 10'(val);
            CFG_VERSION_LIMIT:  lim_proto  = 8'(val);
            CFG_LINE_LIMIT:     lim_line   = 12'(val);
            CFG_MAX_HEADERS:    lim_hdrs   = 8'(val);
            default:
            begin
            end
        endcase
    endtask

    task automatic set_limits(input int unsigned m, input int unsigned r,
                              input int unsigned v, input int unsigned l,
                              input int unsigned h);
        write_reg(CFG_METHOD_LIMIT, m);
        write_reg(CFG_RESOURCE_LIMIT, r);
        write_reg(CFG_VERSION_LIMIT, v);
        write_reg(CFG_LINE_LIMIT, l);
        write_reg(CFG_MAX_HEADERS, h);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || req_ch.valid || parsed_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic flush_draft(input bit drain_first);
        req_byte_t item;
        foreach (draft[i])
        begin
            item.data        = draft[i];
            item.eor         = (i == draft.size() - 1);
            item.drain_first = drain_first && (i == 0);
            request_q.push_back(item);
        end
        sent_bytes += draft.size();
        draft.delete();
    endtask

    function automatic logic [7:0] pick_gap();
        return ($urandom_range(3) == 0) ? CH_TAB : CH_SP;
    endfunction

    function automatic logic [7:0] pick_token_char(input bit uri);
        string      digits = "0123456789abcdefABCDEFgZ";
        int         sel;
        logic [7:0] c;
        sel = $urandom_range(99);
        if (uri && sel < 15)
            return CH_PCT;
        if (uri && sel < 25)
            return CH_PLUS;
        if (sel < 50)
            return digits[$urandom_range(digits.len() - 1)];
        if (sel < 75)
            return 8'($urandom_range(8'h41, 8'h5A));
        do
            c = 8'($urandom);
        while (is_white(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_field_char(input bit key);
        logic [7:0] c;
        if ($urandom_range(99) < 75)
            return 8'($urandom_range(8'h61, 8'h7A));
        do
            c = 8'($urandom);
        while (c == CH_CR || (key && c == CH_COLON));
        return c;
    endfunction

    task automatic add_token(input bit uri, input int n);
        repeat (n) draft.push_back(pick_token_char(uri));
    endtask

    task automatic add_crlf();
        draft.push_back(CH_CR);
        draft.push_back(CH_LF);
    endtask

    task automatic gen_request(input bit drain_first);
        int flaw;
        int n_hdr;
        int n;
        flaw = ($urandom_range(99) < 30) ? $urandom_range(1, 7) : 0;
        if (flaw == 7)
        begin
            repeat ($urandom_range(1, 12)) draft.push_back(8'($urandom));
        end
        else
        begin
            if ($urandom_range(3) == 0)
                draft.push_back(pick_gap());
            add_token(1'b0, $urandom_range(1, 4));
            draft.push_back(pick_gap());
            add_token(1'b1, $urandom_range(1, 6));
            if (flaw != 1)
            begin
                draft.push_back(pick_gap());
                add_token(1'b0, $urandom_range(1, 5));
            end
            if ($urandom_range(4) == 0)
            begin
                draft.push_back(pick_gap());
                add_token(1'b0, $urandom_range(1, 3));
            end
            if ($urandom_range(3) == 0)
                draft.push_back(pick_gap());
            add_crlf();
            n_hdr = (flaw >= 2 && flaw <= 4) ? $urandom_range(1, 2) : $urandom_range(0, 2);
            for (int h = 0; h < n_hdr; h++)
            begin
                if (!(flaw == 3 && h == 0))
                    repeat ($urandom_range(1, 3)) draft.push_back(pick_field_char(1'b1));
                if (!(flaw == 2 && h == 0))
                begin
                    draft.push_back(CH_COLON);
                    repeat ($urandom_range(0, 2)) draft.push_back(CH_SP);
                    if (!(flaw == 4 && h == 0))
                        repeat ($urandom_range(1, 3)) draft.push_back(pick_field_char(1'b0));
                end
                add_crlf();
            end
            add_crlf();
            repeat ($urandom_range(0, 3)) draft.push_back(8'($urandom));
            if (flaw == 6)
                draft.insert($urandom_range(0, draft.size() - 1), CH_CR);
            if (flaw == 5)
            begin
                n = $urandom_range(1, draft.size());
                while (draft.size() > n)
                    void'(draft.pop_back());
            end
        end
        flush_draft(drain_first);
    endtask

    task automatic run_phase(input int unsigned m, input int unsigned r,
                             input int unsigned v, input int unsigned l,
                             input int unsigned h, input int target);
        int start;
        wait_drained();
        set_limits(m, r, v, l, h);
        start = sent_bytes;
        gen_request(1'b0);
        while (sent_bytes - start < target)
            gen_request(1'b0);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.data_byte      = '0;
        req_ch.end_of_request = 1'b0;
        res_ch.ready          = 1'b0;
        cfg_write             = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        lim_method            = RST_METHOD_LIMIT;
        lim_uri               = RST_RESOURCE_LIMIT;
        lim_proto             = RST_VERSION_LIMIT;
        lim_line              = RST_LINE_LIMIT;
        lim_hdrs              = RST_MAX_HEADERS;
        reset_parser();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // escapes: full, non-hex first, non-hex second, cut short at token end
        push_text("G %4a+%zq%4g%7 H\r\nk: v\r\n\r\nx");
        flush_draft(1'b0);
        draft.push_back(8'h00);
        draft.push_back(8'hFF);
        flush_draft(1'b1);

        run_phase(3, 4, 6, 16, 1, 30);
        no_idle = 1'b1;
        run_phase(255, 1023, 255, 4095, 255, 12);
        no_idle = 1'b0;
        run_phase(1, 1, 1, 16, 0, 12);
        run_phase($urandom_range(0, 8), $urandom_range(0, 12), $urandom_range(0, 10),
                  $urandom_range(0, 40), $urandom_range(0, 3), 12);
        run_phase(RST_METHOD_LIMIT, RST_RESOURCE_LIMIT, RST_VERSION_LIMIT,
                  RST_LINE_LIMIT, RST_MAX_HEADERS, 8);
        wait_drained();

        if (parsed_q.size() != 0)
        begin
            errors += parsed_q.size();
            $display("%0d expected results never arrived", parsed_q.size());
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
